### src/field_map_bilinear_lookup_macros.svh
// Assertion helpers used by the block's top-level RTL.
`ifndef FIELD_MAP_BILINEAR_LOOKUP_MACROS_SVH
`define FIELD_MAP_BILINEAR_LOOKUP_MACROS_SVH

// Implication checked outside reset.
`define FMBL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fmbl: implication check failed");

// Property checked at every edge, reset included.
`define FMBL_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("fmbl: reset-time check failed");

`endif

### src/fmbl_pkg.sv
`default_nettype none

package fmbl_pkg;

	localparam int unsigned CFG_IW = 3;
	localparam int unsigned CFG_DW = 32;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [CFG_IW-1:0] {
		CFG_UNIFORM_MODE = 3'd0,
		CFG_UNIFORM_BZ   = 3'd1,
		CFG_FIELD_SCALE  = 3'd2,
		CFG_R_MIN        = 3'd3,
		CFG_Z_MIN        = 3'd4,
		CFG_R_INV_STEP   = 3'd5,
		CFG_Z_INV_STEP   = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic               action;
		logic [15:0]        point_index;
		logic signed [31:0] load_radial;
		logic signed [31:0] load_axial;
		logic               last_point;
		logic signed [31:0] r_pos;
		logic signed [31:0] z_pos;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] radial_out;
		logic signed [31:0] axial_out;
		logic               in_range;
	} res_t;

	typedef struct packed {
		logic               uniform_mode;
		logic signed [31:0] uniform_bz;
		logic [31:0]        field_scale;
		logic signed [31:0] r_min;
		logic signed [31:0] z_min;
		logic [31:0]        r_inv_step;
		logic [31:0]        z_inv_step;
	} cfg_t;

	// lookup request leaving the coordinate stages
	typedef struct packed {
		logic        query;
		logic        hit;
		logic [15:0] tr;
		logic [15:0] tz;
	} lk_t;

	// unscaled field, Q4.28 with headroom
	typedef struct packed {
		logic signed [33:0] radial;
		logic signed [33:0] axial;
		logic               in_range;
	} fld_t;

	typedef struct packed {
		logic we;
		logic re;
	} mem_t;

endpackage

`default_nettype wire

### src/field_map_bilinear_lookup.sv
// channel   | direction | handshake                 | payload
// cfg       | in        | cfg_we                    | cfg_index, cfg_data
// cmd       | in        | cmd_valid / cmd_stall     | cmd (load or query request)
// res       | out       | res_valid / res_stall     | res (one per query)
//
// One request per cycle sustained while res is not stalled; query results leave from a register.
// Two 32x32 coordinate multiplies, the table read, the weight products and the field scaling set the stages.
// Table reads and writes both happen between stages 3 and 4, so requests stay in order.
// Reset clears pipeline valids and the grid-loaded flag and sets config defaults; data regs and tables keep contents.
// A stall on res backs up only as far as the first empty stage.
`default_nettype none

`include "field_map_bilinear_lookup_macros.svh"

module field_map_bilinear_lookup #(
	parameter int unsigned N_R = 256,
	parameter int unsigned N_Z = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fmbl_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [fmbl_pkg::CFG_DW-1:0]    cfg_data,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  fmbl_pkg::cmd_t                 cmd,
	output logic                           res_valid,
	input  logic                           res_stall,
	output fmbl_pkg::res_t                 res
);
	import fmbl_pkg::*;

	localparam int unsigned GP    = N_R * N_Z;
	localparam int unsigned DEPTH = (GP < 65536) ? GP : 65536;
	localparam int unsigned AW    = $clog2(DEPTH);

	cfg_t cfg_q;

	logic          cmd_ready;
	logic          ready_s4, ready_s7;
	logic          valid_s3, valid_s6;
	lk_t           lk;
	mem_t          mem;
	logic [AW-1:0] addr_a0, addr_a1, addr_b0, addr_b1;
	logic [63:0]   wdata;
	logic [63:0]   rd_a0, rd_a1, rd_b0, rd_b1;
	fld_t          fld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.uniform_mode <= 1'b0;
			cfg_q.uniform_bz   <= '0;
			cfg_q.field_scale  <= 32'h0100_0000;
			cfg_q.r_min        <= '0;
			cfg_q.z_min        <= '0;
			cfg_q.r_inv_step   <= 32'h0001_0000;
			cfg_q.z_inv_step   <= 32'h0001_0000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UNIFORM_MODE: cfg_q.uniform_mode <= cfg_data[0];
				CFG_UNIFORM_BZ:   cfg_q.uniform_bz   <= cfg_data;
				CFG_FIELD_SCALE:  cfg_q.field_scale  <= cfg_data;
				CFG_R_MIN:        cfg_q.r_min        <= cfg_data;
				CFG_Z_MIN:        cfg_q.z_min        <= cfg_data;
				CFG_R_INV_STEP:   cfg_q.r_inv_step   <= cfg_data;
				CFG_Z_INV_STEP:   cfg_q.z_inv_step   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cmd_stall = !cmd_ready;

	fmbl_coord #(
		.N_R (N_R),
		.N_Z (N_Z)
	) u_coord (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.ready_s4  (ready_s4),
		.valid_s3  (valid_s3),
		.lk        (lk),
		.mem       (mem),
		.addr_a0   (addr_a0),
		.addr_a1   (addr_a1),
		.addr_b0   (addr_b0),
		.addr_b1   (addr_b1),
		.wdata     (wdata)
	);

	// both copies hold the whole grid; copy a serves the lower row of each cell, copy b the upper one
	fmbl_table #(
		.DEPTH (DEPTH)
	) u_table_a (
		.clk    (clk),
		.we     (mem.we),
		.waddr  (addr_a0),
		.wdata  (wdata),
		.re     (mem.re),
		.raddr0 (addr_a0),
		.raddr1 (addr_a1),
		.rdata0 (rd_a0),
		.rdata1 (rd_a1)
	);

	fmbl_table #(
		.DEPTH (DEPTH)
	) u_table_b (
		.clk    (clk),
		.we     (mem.we),
		.waddr  (addr_a0),
		.wdata  (wdata),
		.re     (mem.re),
		.raddr0 (addr_b0),
		.raddr1 (addr_b1),
		.rdata0 (rd_b0),
		.rdata1 (rd_b1)
	);

	fmbl_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s3 (valid_s3),
		.lk       (lk),
		.ready_s4 (ready_s4),
		.rd_a0    (rd_a0),
		.rd_a1    (rd_a1),
		.rd_b0    (rd_b0),
		.rd_b1    (rd_b1),
		.ready_s7 (ready_s7),
		.valid_s6 (valid_s6),
		.fld      (fld)
	);

	fmbl_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.field_scale (cfg_q.field_scale),
		.valid_s6    (valid_s6),
		.fld         (fld),
		.ready_s7    (ready_s7),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

	`FMBL_ASSERT_IMP(a_stall_from_output, cmd_stall, res_valid && res_stall)
	`FMBL_ASSERT_IMP(a_table_one_access, mem.we, !mem.re)
	`FMBL_ASSERT_IMP(a_miss_gives_zero, res_valid && !res.in_range, (res.radial_out == '0) && (res.axial_out == '0))
	`FMBL_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> (!res_valid && !cmd_stall))

endmodule

`default_nettype wire

### src/fmbl_table.sv
`default_nettype none

module fmbl_table #(
	parameter int unsigned DEPTH = 65536,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [63:0]   rdata0,
	output logic [63:0]   rdata1
);
	logic [63:0] words_q [DEPTH];
	logic [63:0] rd0_q;
	logic [63:0] rd1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			words_q[waddr] <= wdata;
		end
		if (re) begin
			rd0_q <= words_q[raddr0];
			rd1_q <= words_q[raddr1];
		end
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;

endmodule

`default_nettype wire

### src/fmbl_coord.sv
`default_nettype none

module fmbl_coord #(
	parameter int unsigned N_R = 256,
	parameter int unsigned N_Z = 256,
	localparam int unsigned GP = N_R * N_Z,
	localparam int unsigned DEPTH = (GP < 65536) ? GP : 65536,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fmbl_pkg::cfg_t  cfg,
	input  logic            cmd_valid,
	input  fmbl_pkg::cmd_t  cmd,
	output logic            cmd_ready,
	input  logic            ready_s4,
	output logic            valid_s3,
	output fmbl_pkg::lk_t   lk,
	output fmbl_pkg::mem_t  mem,
	output logic [AW-1:0]   addr_a0,
	output logic [AW-1:0]   addr_a1,
	output logic [AW-1:0]   addr_b0,
	output logic [AW-1:0]   addr_b1,
	output logic [63:0]     wdata
);
	import fmbl_pkg::*;

	localparam int unsigned RW = $clog2(N_R);
	localparam int unsigned ZW = $clog2(N_Z);
	localparam int unsigned GW = $clog2(GP);

	logic v_s1, v_s2, v_s3;
	logic ready_s1, ready_s2, ready_s3;
	logic loaded_q;
	logic go;

	logic        act_s1, last_s1;
	logic [15:0] idx_s1;
	logic [63:0] wd_s1;
	logic [32:0] dr_s1, dz_s1;

	logic        act_s2, last_s2, neg_r_s2, neg_z_s2;
	logic [15:0] idx_s2;
	logic [63:0] wd_s2;
	logic [63:0] cr_s2, cz_s2;

	logic          act_s3, last_s3, wok_s3, geo_s3;
	logic [63:0]   wd_s3;
	logic [15:0]   tr_s3, tz_s3;
	logic [AW-1:0] a0_s3, a1_s3, b0_s3, b1_s3;

	logic [32:0]   dr_c, dz_c;
	logic          ok_r, ok_z, wok_c;
	logic [RW-1:0] ir;
	logic [ZW-1:0] iz;
	logic [GW-1:0] base, nb_a1, nb_b0, nb_b1;

	assign ready_s3  = !v_s3 || ready_s4;
	assign ready_s2  = !v_s2 || ready_s3;
	assign ready_s1  = !v_s1 || ready_s2;
	assign cmd_ready = ready_s1;

	assign dr_c = {cmd.r_pos[31], cmd.r_pos} - {cfg.r_min[31], cfg.r_min};
	assign dz_c = {cmd.z_pos[31], cmd.z_pos} - {cfg.z_min[31], cfg.z_min};

	assign ok_r  = !neg_r_s2 && (cr_s2[63:32] < 32'(N_R - 1));
	assign ok_z  = !neg_z_s2 && (cz_s2[63:32] < 32'(N_Z - 1));
	assign ir    = cr_s2[32 +: RW];
	assign iz    = cz_s2[32 +: ZW];
	assign base  = GW'(ir) * GW'(N_Z) + GW'(iz);
	assign nb_a1 = base + GW'(1);
	assign nb_b0 = base + GW'(N_Z);
	assign nb_b1 = nb_b0 + GW'(1);
	assign wok_c = {16'd0, idx_s2} < 32'(GP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			loaded_q <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= cmd_valid;
			if (ready_s2) v_s2 <= v_s1;
			if (ready_s3) v_s3 <= v_s2;
			if (go && act_s3 == ACT_LOAD && last_s3) loaded_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			act_s1  <= cmd.action;
			idx_s1  <= cmd.point_index;
			wd_s1   <= {cmd.load_radial, cmd.load_axial};
			last_s1 <= cmd.last_point;
			dr_s1   <= dr_c;
			dz_s1   <= dz_c;
		end
		if (ready_s2) begin
			act_s2   <= act_s1;
			idx_s2   <= idx_s1;
			wd_s2    <= wd_s1;
			last_s2  <= last_s1;
			neg_r_s2 <= dr_s1[32];
			neg_z_s2 <= dz_s1[32];
			cr_s2    <= {32'd0, dr_s1[31:0]} * {32'd0, cfg.r_inv_step};
			cz_s2    <= {32'd0, dz_s1[31:0]} * {32'd0, cfg.z_inv_step};
		end
		if (ready_s3) begin
			act_s3  <= act_s2;
			wd_s3   <= wd_s2;
			last_s3 <= last_s2;
			wok_s3  <= wok_c;
			geo_s3  <= ok_r && ok_z;
			tr_s3   <= cr_s2[31:16];
			tz_s3   <= cz_s2[31:16];
			a0_s3   <= (act_s2 == ACT_QUERY) ? base[AW-1:0] : idx_s2[AW-1:0];
			a1_s3   <= nb_a1[AW-1:0];
			b0_s3   <= nb_b0[AW-1:0];
			b1_s3   <= nb_b1[AW-1:0];
		end
	end

	// table access happens as the item leaves this stage, loads and reads in order
	assign go     = v_s3 && ready_s4;
	assign mem.we = go && act_s3 == ACT_LOAD && wok_s3;
	assign mem.re = go && act_s3 == ACT_QUERY;

	assign valid_s3 = v_s3;
	assign lk.query = act_s3 == ACT_QUERY;
	assign lk.hit   = geo_s3 && loaded_q;
	assign lk.tr    = tr_s3;
	assign lk.tz    = tz_s3;

	assign addr_a0 = a0_s3;
	assign addr_a1 = a1_s3;
	assign addr_b0 = b0_s3;
	assign addr_b1 = b1_s3;
	assign wdata   = wd_s3;

endmodule

`default_nettype wire

### src/fmbl_interp.sv
`default_nettype none

module fmbl_interp (
	input  logic           clk,
	input  logic           arst_n,
	input  fmbl_pkg::cfg_t cfg,
	input  logic           valid_s3,
	input  fmbl_pkg::lk_t  lk,
	output logic           ready_s4,
	input  logic [63:0]    rd_a0,
	input  logic [63:0]    rd_a1,
	input  logic [63:0]    rd_b0,
	input  logic [63:0]    rd_b1,
	input  logic           ready_s7,
	output logic           valid_s6,
	output fmbl_pkg::fld_t fld
);
	import fmbl_pkg::*;

	logic v_s4, v_s5, v_s6;
	logic ready_s5, ready_s6;

	logic [16:0] ntr, ntz;
	logic [32:0] w_c [4];

	logic        hit_s4;
	logic [32:0] w_s4 [4];

	logic signed [31:0] vr [4];
	logic signed [31:0] va [4];

	logic               hit_s5;
	logic signed [65:0] pr_s5 [4];
	logic signed [65:0] pa_s5 [4];

	logic signed [67:0] sr, sa;
	fld_t               fld_c;
	fld_t               fld_s6;

	assign ready_s6 = !v_s6 || ready_s7;
	assign ready_s5 = !v_s5 || ready_s6;
	assign ready_s4 = !v_s4 || ready_s5;

	// weight order: (r,z), (r,z+1), (r+1,z), (r+1,z+1)
	assign ntr    = 17'd65536 - {1'b0, lk.tr};
	assign ntz    = 17'd65536 - {1'b0, lk.tz};
	assign w_c[0] = {16'd0, ntr} * {16'd0, ntz};
	assign w_c[1] = {16'd0, ntr} * {17'd0, lk.tz};
	assign w_c[2] = {17'd0, lk.tr} * {16'd0, ntz};
	assign w_c[3] = {17'd0, lk.tr} * {17'd0, lk.tz};

	assign vr[0] = rd_a0[63:32];
	assign vr[1] = rd_a1[63:32];
	assign vr[2] = rd_b0[63:32];
	assign vr[3] = rd_b1[63:32];
	assign va[0] = rd_a0[31:0];
	assign va[1] = rd_a1[31:0];
	assign va[2] = rd_b0[31:0];
	assign va[3] = rd_b1[31:0];

	assign sr = pr_s5[0] + pr_s5[1] + pr_s5[2] + pr_s5[3] + 68'sd2147483648;
	assign sa = pa_s5[0] + pa_s5[1] + pa_s5[2] + pa_s5[3] + 68'sd2147483648;

	always_comb begin
		if (cfg.uniform_mode) begin
			fld_c.radial   = '0;
			fld_c.axial    = 34'(cfg.uniform_bz);
			fld_c.in_range = 1'b1;
		end else if (!hit_s5) begin
			fld_c.radial   = '0;
			fld_c.axial    = '0;
			fld_c.in_range = 1'b0;
		end else begin
			fld_c.radial   = sr[65:32];
			fld_c.axial    = sa[65:32];
			fld_c.in_range = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ready_s4) v_s4 <= valid_s3 && lk.query;
			if (ready_s5) v_s5 <= v_s4;
			if (ready_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			hit_s4 <= lk.hit;
			for (int i = 0; i < 4; i++) begin
				w_s4[i] <= w_c[i];
			end
		end
		if (ready_s5) begin
			hit_s5 <= hit_s4;
			for (int i = 0; i < 4; i++) begin
				pr_s5[i] <= $signed({1'b0, w_s4[i]}) * vr[i];
				pa_s5[i] <= $signed({1'b0, w_s4[i]}) * va[i];
			end
		end
		if (ready_s6) begin
			fld_s6 <= fld_c;
		end
	end

	assign valid_s6 = v_s6;
	assign fld      = fld_s6;

endmodule

`default_nettype wire

### src/fmbl_scale.sv
`default_nettype none

module fmbl_scale (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [31:0]    field_scale,
	input  logic           valid_s6,
	input  fmbl_pkg::fld_t fld,
	output logic           ready_s7,
	output logic           res_valid,
	input  logic           res_stall,
	output fmbl_pkg::res_t res
);
	import fmbl_pkg::*;

	logic v_s7, res_valid_q;
	logic ready_s8;

	logic signed [66:0] pr_c, pa_c;
	logic signed [66:0] pr_s7, pa_s7;
	logic               rng_s7;
	logic signed [66:0] tr, ta;
	res_t               res_q;

	function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
		logic signed [31:0] r;
		if (v > 43'sd2147483647) begin
			r = 32'sh7fff_ffff;
		end else if (v < -43'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign ready_s8 = !res_valid_q || !res_stall;
	assign ready_s7 = !v_s7 || ready_s8;

	assign pr_c = fld.radial * $signed({1'b0, field_scale});
	assign pa_c = fld.axial * $signed({1'b0, field_scale});

	// round half up, drop the scale fraction
	assign tr = pr_s7 + 67'sd8388608;
	assign ta = pa_s7 + 67'sd8388608;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ready_s7) v_s7 <= valid_s6;
			if (ready_s8) res_valid_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s7) begin
			pr_s7  <= pr_c;
			pa_s7  <= pa_c;
			rng_s7 <= fld.in_range;
		end
		if (ready_s8) begin
			res_q.radial_out <= sat32($signed(tr[66:24]));
			res_q.axial_out  <= sat32($signed(ta[66:24]));
			res_q.in_range   <= rng_s7;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire
